// ----- design/assert_macros.svh -----
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ----- design/tlnt_pkg.sv -----
package tlnt_pkg;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // option codes and subnegotiation codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] TT_IS     = 8'd0;
  localparam logic [7:0] TT_SEND   = 8'd1;

  // plain data bytes with a special meaning
  localparam logic [7:0] C_CR    = 8'd13;
  localparam logic [7:0] C_LF    = 8'd10;
  localparam logic [7:0] C_BS    = 8'd8;
  localparam logic [7:0] C_DEL   = 8'd127;
  localparam logic [7:0] C_SPACE = 8'd32;

  // result action codes
  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_SHOW = 3'd1;
  localparam logic [2:0] ACT_CR   = 3'd2;
  localparam logic [2:0] ACT_LF   = 3'd3;
  localparam logic [2:0] ACT_BS   = 3'd4;

  // result run lengths
  localparam int unsigned SeqW       = 4;
  localparam logic [SeqW-1:0] LEN_ONE   = 4'd1;
  localparam logic [SeqW-1:0] LEN_REPLY = 4'd3;
  localparam logic [SeqW-1:0] LEN_TTYPE = 4'd10;
  localparam logic [SeqW-1:0] LEN_BOTH  = 4'd13;

  // job queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // what the back end has to send for one input byte
  typedef enum logic [1:0] {
    JOB_ONE,       // single display or show result
    JOB_REPLY,     // IAC verb option
    JOB_REPLY_TT,  // IAC WILL TTYPE, then the ttype subnegotiation
    JOB_TTYPE      // ttype subnegotiation alone
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] act;
    logic [7:0] verb;
    logic [7:0] data;
    logic       sga_on;
    logic       echo_off;
  } job_t;

  // IAC SB TTYPE IS "ANSI" IAC SE
  function automatic logic [7:0] ttype_byte(logic [SeqW-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = B_IAC;
      4'd1:    b = B_SB;
      4'd2:    b = OPT_TTYPE;
      4'd3:    b = TT_IS;
      4'd4:    b = 8'h41;
      4'd5:    b = 8'h4e;
      4'd6:    b = 8'h53;
      4'd7:    b = 8'h49;
      4'd8:    b = B_IAC;
      4'd9:    b = B_SE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- design/tlnt_front.sv -----
`include "assert_macros.svh"

module tlnt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          full_i,
  output logic          push_o,
  output tlnt_pkg::job_t job_o
);
  import tlnt_pkg::*;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_IAC,
    PH_VERB
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] verb_q, verb_d;
  logic       subneg_q, subneg_d;
  logic       sopt_v_q, sopt_v_d;
  logic [7:0] sopt_q, sopt_d;
  logic       sverb_v_q, sverb_v_d;
  logic [7:0] sverb_q, sverb_d;
  logic       char_q, char_d;
  logic       echo_q, echo_d;
  logic       push;
  job_kind_e  kind;
  logic [2:0] act;
  logic [7:0] rverb;
  logic [7:0] data;

  // classify the byte and work out the next parser state
  always_comb begin
    phase_d   = phase_q;
    verb_d    = verb_q;
    subneg_d  = subneg_q;
    sopt_v_d  = sopt_v_q;
    sopt_d    = sopt_q;
    sverb_v_d = sverb_v_q;
    sverb_d   = sverb_q;
    char_d    = char_q;
    echo_d    = echo_q;
    push      = 1'b0;
    kind      = JOB_ONE;
    act       = ACT_SEND;
    rverb     = 8'h00;
    data      = 8'h00;

    if (subneg_q) begin
      // inside a subnegotiation
      if (phase_q == PH_IAC) begin
        phase_d = PH_DATA;
        if (rx_byte_i == B_SE) begin
          subneg_d = 1'b0;
          if (sopt_v_q && sopt_q == OPT_TTYPE && sverb_v_q && sverb_q == TT_SEND) begin
            push = 1'b1;
            kind = JOB_TTYPE;
          end
        end
      end else if (rx_byte_i == B_IAC) begin
        phase_d = PH_IAC;
      end else if (!sopt_v_q) begin
        sopt_v_d = 1'b1;
        sopt_d   = rx_byte_i;
      end else if (!sverb_v_q) begin
        sverb_v_d = 1'b1;
        sverb_d   = rx_byte_i;
      end
    end else begin
      unique case (phase_q)
        PH_IAC: begin
          phase_d = PH_DATA;
          if (rx_byte_i == B_IAC) begin
            push = 1'b1;
            act  = ACT_SHOW;
            data = B_IAC;
          end else if (rx_byte_i == B_SB) begin
            subneg_d  = 1'b1;
            sopt_v_d  = 1'b0;
            sopt_d    = 8'h00;
            sverb_v_d = 1'b0;
            sverb_d   = 8'h00;
          end else if (rx_byte_i == B_WILL || rx_byte_i == B_WONT ||
                       rx_byte_i == B_DO || rx_byte_i == B_DONT) begin
            verb_d  = rx_byte_i;
            phase_d = PH_VERB;
          end
        end
        PH_VERB: begin
          // option policy
          phase_d = PH_DATA;
          push    = 1'b1;
          kind    = JOB_REPLY;
          data    = rx_byte_i;
          if (rx_byte_i == OPT_ECHO) begin
            if (verb_q == B_WILL) begin
              echo_d = 1'b1;
              rverb  = B_DO;
            end else if (verb_q == B_WONT) begin
              echo_d = 1'b0;
              rverb  = B_DONT;
            end else begin
              rverb  = B_WONT;
            end
          end else if (rx_byte_i == OPT_SGA) begin
            if (verb_q == B_WILL) begin
              char_d = 1'b1;
              rverb  = B_DO;
            end else if (verb_q == B_WONT) begin
              char_d = 1'b0;
              rverb  = B_DONT;
            end else if (verb_q == B_DO) begin
              char_d = 1'b1;
              rverb  = B_WILL;
            end else begin
              char_d = 1'b0;
              rverb  = B_WONT;
            end
          end else if (rx_byte_i == OPT_TTYPE) begin
            if (verb_q == B_DO) begin
              kind  = JOB_REPLY_TT;
              rverb = B_WILL;
            end else if (verb_q == B_WILL) begin
              rverb = B_DONT;
            end else begin
              rverb = B_WONT;
            end
          end else if (verb_q == B_WILL) begin
            rverb = B_DONT;
          end else if (verb_q == B_DO) begin
            rverb = B_WONT;
          end else begin
            push = 1'b0;
          end
        end
        default: begin
          // plain data
          phase_d = PH_DATA;
          if (rx_byte_i == B_IAC) begin
            phase_d = PH_IAC;
          end else if (rx_byte_i == C_CR) begin
            push = 1'b1;
            act  = ACT_CR;
          end else if (rx_byte_i == C_LF) begin
            push = 1'b1;
            act  = ACT_LF;
          end else if (rx_byte_i == C_BS || rx_byte_i == C_DEL) begin
            push = 1'b1;
            act  = ACT_BS;
          end else if (rx_byte_i >= C_SPACE) begin
            push = 1'b1;
            act  = ACT_SHOW;
            data = rx_byte_i;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DATA;
      verb_q    <= 8'h00;
      subneg_q  <= 1'b0;
      sopt_v_q  <= 1'b0;
      sopt_q    <= 8'h00;
      sverb_v_q <= 1'b0;
      sverb_q   <= 8'h00;
      char_q    <= 1'b0;
      echo_q    <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      verb_q    <= verb_d;
      subneg_q  <= subneg_d;
      sopt_v_q  <= sopt_v_d;
      sopt_q    <= sopt_d;
      sverb_v_q <= sverb_v_d;
      sverb_q   <= sverb_d;
      char_q    <= char_d;
      echo_q    <= echo_d;
    end
  end

  assign push_o = take_i & push;
  assign job_o  = '{kind: kind, act: act, verb: rverb, data: data,
                    sga_on: char_d, echo_off: echo_d};

  `ASSERT_NEVER(a_front_push_full, clk_i, rst_ni, push_o && full_i, "push into full queue")
  `ASSERT_NEVER(a_front_subneg_verb, clk_i, rst_ni, subneg_q && phase_q == PH_VERB,
                "verb phase inside subnegotiation")

endmodule

// ----- design/tlnt_queue.sv -----
`include "assert_macros.svh"

module tlnt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlnt_pkg::job_t job_i,
  input  logic           pop_i,
  output tlnt_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);
  import tlnt_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  // pointers and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign job_o   = mem_q[rd_q];
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);

  `ASSERT_NEVER(a_queue_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_CLK(a_queue_cnt_range, clk_i, rst_ni, cnt_q <= QCntW'(QDepth), "queue count overrun")

endmodule

// ----- design/tlnt_back.sv -----
`include "assert_macros.svh"

module tlnt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlnt_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     action_o,
  output logic [7:0]     data_byte_o,
  output logic           last_of_run_o,
  output logic           char_mode_flag_o,
  output logic           no_echo_flag_o
);
  import tlnt_pkg::*;

  logic [SeqW-1:0] idx_q, idx_d;
  logic            vld_q, vld_d;
  logic [2:0]      act_q;
  logic [7:0]      data_q;
  logic            last_q, cm_q, eo_q;
  logic            load;
  logic [SeqW-1:0] len;
  logic            last;
  logic [2:0]      act;
  logic [7:0]      data;

  // run length of the current job
  always_comb begin
    case (job_i.kind)
      JOB_REPLY:    len = LEN_REPLY;
      JOB_REPLY_TT: len = LEN_BOTH;
      JOB_TTYPE:    len = LEN_TTYPE;
      default:      len = LEN_ONE;
    endcase
  end

  // pick the result byte at the current run position
  always_comb begin
    act  = ACT_SEND;
    data = 8'h00;
    case (job_i.kind)
      JOB_ONE: begin
        act  = job_i.act;
        data = job_i.data;
      end
      JOB_TTYPE: begin
        data = ttype_byte(idx_q);
      end
      default: begin
        if (idx_q == 4'd0) begin
          data = B_IAC;
        end else if (idx_q == 4'd1) begin
          data = job_i.verb;
        end else if (idx_q == 4'd2) begin
          data = job_i.data;
        end else begin
          data = ttype_byte(idx_q - LEN_REPLY);
        end
      end
    endcase
  end

  assign last  = (idx_q == len - 1'b1);
  assign load  = !empty_i && (!vld_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + 1'b1;
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  // run position and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q  <= act;
      data_q <= data;
      last_q <= last;
      cm_q   <= job_i.sga_on;
      eo_q   <= job_i.echo_off;
    end
  end

  assign out_valid_o      = vld_q;
  assign action_o         = act_q;
  assign data_byte_o      = data_q;
  assign last_of_run_o    = last_q;
  assign char_mode_flag_o = cm_q;
  assign no_echo_flag_o   = eo_q;

  `ASSERT_CLK(a_back_mid_run, clk_i, rst_ni, idx_q != '0 |-> !empty_i,
              "job left the queue in the middle of a run")
  `ASSERT_CLK(a_back_step, clk_i, rst_ni, load && !last |=> idx_q == $past(idx_q) + 1'b1,
              "run position did not advance")

endmodule

// ----- design/telnet_receive_negotiator_unit.sv -----
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | rx_byte_i
// out     | output    | out_valid_o / out_stall_i | action_o, data_byte_o, last_of_run_o,
//         |           |                           | char_mode_flag_o, no_echo_flag_o
//
// one received byte is taken per cycle while the four-entry job queue has room
// each byte with results leaves one job; the back end sends one result per cycle while
// out_stall_i is low, so a run is 1 result, an option reply 3, a ttype answer 10 or 13
// out_stall_i holds the back end; input stalls only when the queue is full
// reset clears parser state, queue pointers and the output valid at once
module telnet_receive_negotiator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] data_byte_o,
  output logic       last_of_run_o,
  output logic       char_mode_flag_o,
  output logic       no_echo_flag_o
);
  import tlnt_pkg::*;

  logic full, empty, push, pop, take;
  job_t job_in, job_out;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  // parser and option policy
  tlnt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  // job queue
  tlnt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // result sequencer
  tlnt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_out),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .data_byte_o      (data_byte_o),
    .last_of_run_o    (last_of_run_o),
    .char_mode_flag_o (char_mode_flag_o),
    .no_echo_flag_o   (no_echo_flag_o)
  );

endmodule
